// ===== hw/rtl/uvst_pkg.sv =====
// ----------------------------------------------------------------------------
// uvst_pkg
// shared types, register indexes and vertex order tables of the sphere
// cell tessellator
// ----------------------------------------------------------------------------
package uvst_pkg;

    // configuration register indexes
    localparam logic [0:0] REG_RADIUS     = 1'b0;
    localparam logic [0:0] REG_RESOLUTION = 1'b1;

    localparam logic [15:0] RADIUS_RESET     = 16'd256;
    localparam logic [8:0]  RESOLUTION_RESET = 9'd16;

    // width of a corner longitude index (segment plus one)
    localparam int unsigned JW = 9;
    // width of a corner latitude index (ring plus one)
    localparam int unsigned IW = 7;

    // one row of the trig table: quadrant-0 sin and cos in q1.30 plus
    // rounded texture offsets for the same (quarter, offset) pair
    typedef struct packed {
        logic [30:0] sv;
        logic [30:0] cv;
        logic [13:0] uoff;
        logic [14:0] voff;
        logic [13:0] aoff;
    } t_trig_word;

    // corner select for one vertex of a cell
    typedef struct packed {
        logic jsel;
        logic isel;
        logic mir;
        logic apex;
    } t_vsel;

    // per vertex flags that travel down the pipeline
    typedef struct packed {
        logic mir;
        logic apex;
        logic last;
        logic bad;
    } t_vflags;

    // ordinary band: a b c c d a, then mirrored d c b b a d
    function automatic t_vsel band_vsel(input logic [3:0] idx);
        t_vsel v;
        unique case (idx)
            4'd0:    v = '{jsel: 1'b0, isel: 1'b0, mir: 1'b0, apex: 1'b0};
            4'd1:    v = '{jsel: 1'b1, isel: 1'b0, mir: 1'b0, apex: 1'b0};
            4'd2:    v = '{jsel: 1'b1, isel: 1'b1, mir: 1'b0, apex: 1'b0};
            4'd3:    v = '{jsel: 1'b1, isel: 1'b1, mir: 1'b0, apex: 1'b0};
            4'd4:    v = '{jsel: 1'b0, isel: 1'b1, mir: 1'b0, apex: 1'b0};
            4'd5:    v = '{jsel: 1'b0, isel: 1'b0, mir: 1'b0, apex: 1'b0};
            4'd6:    v = '{jsel: 1'b0, isel: 1'b1, mir: 1'b1, apex: 1'b0};
            4'd7:    v = '{jsel: 1'b1, isel: 1'b1, mir: 1'b1, apex: 1'b0};
            4'd8:    v = '{jsel: 1'b1, isel: 1'b0, mir: 1'b1, apex: 1'b0};
            4'd9:    v = '{jsel: 1'b1, isel: 1'b0, mir: 1'b1, apex: 1'b0};
            4'd10:   v = '{jsel: 1'b0, isel: 1'b0, mir: 1'b1, apex: 1'b0};
            default: v = '{jsel: 1'b0, isel: 1'b1, mir: 1'b1, apex: 1'b0};
        endcase
        return v;
    endfunction

    // top ring: a b apex, then mirrored a apex b
    function automatic t_vsel top_vsel(input logic [3:0] idx);
        t_vsel v;
        unique case (idx)
            4'd0:    v = '{jsel: 1'b0, isel: 1'b0, mir: 1'b0, apex: 1'b0};
            4'd1:    v = '{jsel: 1'b1, isel: 1'b0, mir: 1'b0, apex: 1'b0};
            4'd2:    v = '{jsel: 1'b0, isel: 1'b0, mir: 1'b0, apex: 1'b1};
            4'd3:    v = '{jsel: 1'b0, isel: 1'b0, mir: 1'b1, apex: 1'b0};
            4'd4:    v = '{jsel: 1'b0, isel: 1'b0, mir: 1'b1, apex: 1'b1};
            default: v = '{jsel: 1'b1, isel: 1'b0, mir: 1'b1, apex: 1'b0};
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/uvst_trig_rom.sv =====
// ----------------------------------------------------------------------------
// uvst_trig_rom
// two-port registered rom of quadrant-0 sin/cos and texture offsets,
// one row per (quarter count, offset) pair
// ----------------------------------------------------------------------------
module uvst_trig_rom #(
    parameter int unsigned QMAX = 64,
    parameter int unsigned AW   = 12
) (
    input  logic                  i_clk,
    input  logic [AW-1:0]         i_addr_a,
    input  logic [AW-1:0]         i_addr_b,
    output uvst_pkg::t_trig_word  o_word_a,
    output uvst_pkg::t_trig_word  o_word_b
);
    import uvst_pkg::*;

    localparam int unsigned DEPTH = QMAX * (QMAX + 1) / 2;
    localparam longint unsigned ONE    = 64'd1 << 30;
    localparam longint unsigned HALFPI = 64'd1686629713;

    t_trig_word rom [DEPTH];

    // rows for quarter count qn start at qn*(qn-1)/2
    for (genvar gq = 1; gq <= QMAX; gq++) begin : g_q
        for (genvar gm = 0; gm < gq; gm++) begin : g_m
            localparam longint unsigned QN = gq;
            localparam longint unsigned MM = gm;
            localparam longint unsigned X  = (MM * HALFPI + QN / 2) / QN;
            localparam longint unsigned X2 = (X * X) >> 30;
            // sine series through x^13
            localparam longint unsigned S1 = ONE - ((X2 * ONE / 64'd156) >> 30);
            localparam longint unsigned S2 = ONE - ((X2 * S1 / 64'd110) >> 30);
            localparam longint unsigned S3 = ONE - ((X2 * S2 / 64'd72) >> 30);
            localparam longint unsigned S4 = ONE - ((X2 * S3 / 64'd42) >> 30);
            localparam longint unsigned S5 = ONE - ((X2 * S4 / 64'd20) >> 30);
            localparam longint unsigned S6 = ONE - ((X2 * S5 / 64'd6) >> 30);
            localparam longint unsigned SV = (X * S6) >> 30;
            // cosine series through x^12
            localparam longint unsigned C1 = ONE - ((X2 * ONE / 64'd132) >> 30);
            localparam longint unsigned C2 = ONE - ((X2 * C1 / 64'd90) >> 30);
            localparam longint unsigned C3 = ONE - ((X2 * C2 / 64'd56) >> 30);
            localparam longint unsigned C4 = ONE - ((X2 * C3 / 64'd30) >> 30);
            localparam longint unsigned C5 = ONE - ((X2 * C4 / 64'd12) >> 30);
            localparam longint unsigned C6 = ONE - ((X2 * C5 / 64'd2) >> 30);
            localparam longint unsigned CV = C6 & 64'h7FFF_FFFF;
            // rounded texture offsets within one quarter
            localparam longint unsigned UOFF = (MM * 64'd32768 + 2 * QN) / (4 * QN);
            localparam longint unsigned VOFF = (MM * 64'd65536 + 2 * QN) / (4 * QN);
            localparam longint unsigned AOFF =
                ((2 * MM + 64'd1) * 64'd16384 + 2 * QN) / (4 * QN);
            localparam int unsigned IDX = gq * (gq - 1) / 2 + gm;

            assign rom[IDX] = {31'(SV), 31'(CV), 14'(UOFF), 15'(VOFF), 14'(AOFF)};
        end
    end

    always_ff @(posedge i_clk) begin
        o_word_a <= rom[i_addr_a];
        o_word_b <= rom[i_addr_b];
    end

endmodule

// ===== hw/rtl/uvst_expander.sv =====
// ----------------------------------------------------------------------------
// uvst_expander
// takes one cell per command and issues its vertex requests, one per cycle
// ----------------------------------------------------------------------------
module uvst_expander #(
    parameter int unsigned QW = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [5:0]                  i_ring,
    input  logic [7:0]                  i_segment,
    input  logic [QW-1:0]               i_qn,
    output logic                        o_req_valid,
    output logic [uvst_pkg::JW-1:0]     o_req_jj,
    output logic [uvst_pkg::IW-1:0]     o_req_ii,
    output uvst_pkg::t_vflags           o_req_flags
);
    import uvst_pkg::*;

    localparam logic [1:0] KIND_BAD  = 2'd0;
    localparam logic [1:0] KIND_TOP  = 2'd1;
    localparam logic [1:0] KIND_BAND = 2'd2;

    localparam logic [3:0] LAST_BAD  = 4'd0;
    localparam logic [3:0] LAST_TOP  = 4'd5;
    localparam logic [3:0] LAST_BAND = 4'd11;

    logic        r_active;
    logic [3:0]  r_idx;
    logic [1:0]  r_kind;
    logic [5:0]  r_ring;
    logic [7:0]  r_seg;

    logic        w_accept;
    logic        w_final;
    logic [3:0]  w_last_idx;
    logic [1:0]  w_kind;
    t_vsel       w_vsel;

    always_comb begin
        unique case (r_kind)
            KIND_BAD:  w_last_idx = LAST_BAD;
            KIND_TOP:  w_last_idx = LAST_TOP;
            default:   w_last_idx = LAST_BAND;
        endcase
    end

    assign w_final  = (r_idx == w_last_idx);
    assign busy     = r_active && !w_final;
    assign w_accept = start && !busy;

    // classify the incoming cell
    always_comb begin
        priority if ((16'(i_ring) >= 16'(i_qn)) ||
                     (16'(i_segment) >= (16'(i_qn) << 2)))
            w_kind = KIND_BAD;
        else if ((16'(i_ring) + 16'd1) == 16'(i_qn))
            w_kind = KIND_TOP;
        else
            w_kind = KIND_BAND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_kind   <= KIND_BAD;
        end else if (w_accept) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_kind   <= w_kind;
        end else if (r_active) begin
            if (w_final) begin
                r_active <= 1'b0;
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ring <= i_ring;
            r_seg  <= i_segment;
        end
    end

    always_comb begin
        unique case (r_kind)
            KIND_BAD:  w_vsel = '0;
            KIND_TOP:  w_vsel = top_vsel(r_idx);
            default:   w_vsel = band_vsel(r_idx);
        endcase
    end

    assign o_req_valid      = r_active;
    assign o_req_jj         = JW'(r_seg) + JW'(w_vsel.jsel);
    assign o_req_ii         = IW'(r_ring) + IW'(w_vsel.isel);
    assign o_req_flags.mir  = w_vsel.mir;
    assign o_req_flags.apex = w_vsel.apex;
    assign o_req_flags.last = w_final;
    assign o_req_flags.bad  = (r_kind == KIND_BAD);

endmodule

// ===== hw/rtl/uvst_vertex_pipe.sv =====
// ----------------------------------------------------------------------------
// uvst_vertex_pipe
// per vertex pipeline: angle split, trig lookup, normal products,
// position scaling and mirroring
// ----------------------------------------------------------------------------
module uvst_vertex_pipe #(
    parameter int unsigned QMAX = 64,
    parameter int unsigned QW   = 7,
    parameter int unsigned AW   = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [QW-1:0]               i_qn,
    input  logic [15:0]                 i_radius,
    input  logic                        i_req_valid,
    input  logic [uvst_pkg::JW-1:0]     i_req_jj,
    input  logic [uvst_pkg::IW-1:0]     i_req_ii,
    input  uvst_pkg::t_vflags           i_req_flags,
    output logic                        o_valid,
    output logic signed [16:0]          o_pos_x,
    output logic signed [16:0]          o_pos_y,
    output logic signed [16:0]          o_pos_z,
    output logic signed [15:0]          o_norm_x,
    output logic signed [15:0]          o_norm_y,
    output logic signed [15:0]          o_norm_z,
    output logic [15:0]                 o_tex_u,
    output logic [15:0]                 o_tex_v,
    output logic                        o_last_vertex,
    output logic                        o_bad_cell
);
    import uvst_pkg::*;

    // quarter boundaries and table base for the current resolution
    logic [15:0]    r_q1, r_q2, r_q3, r_q4;
    logic [AW-1:0]  r_base;
    logic [2*QW-1:0] w_tri;

    assign w_tri = (2*QW)'(i_qn) * (2*QW)'(i_qn - QW'(1));

    always_ff @(posedge i_clk) begin
        r_q1   <= 16'(i_qn);
        r_q2   <= 16'(i_qn) << 1;
        r_q3   <= (16'(i_qn) << 1) + 16'(i_qn);
        r_q4   <= 16'(i_qn) << 2;
        r_base <= AW'(w_tri >> 1);
    end

    // stage 1: request
    logic            r1_valid;
    logic [JW-1:0]   r1_jj;
    logic [IW-1:0]   r1_ii;
    t_vflags         r1_flags;

    // stage 2: table addresses
    logic            r2_valid;
    logic [AW-1:0]   r2_aj, r2_ai;
    logic [2:0]      r2_q;
    t_vflags         r2_flags;

    // stage 3: table data
    logic            r3_valid;
    logic [2:0]      r3_q;
    t_vflags         r3_flags;
    t_trig_word      w_rom_j, w_rom_i;

    // stage 4: normal products
    logic            r4_valid;
    logic [61:0]     r4_pnx, r4_pnz;
    logic            r4_nxneg, r4_nzneg;
    logic [14:0]     r4_ny;
    logic [15:0]     r4_u, r4_v;
    t_vflags         r4_flags;

    // stage 5: rounded normals
    logic            r5_valid;
    logic [14:0]     r5_nx, r5_ny, r5_nz;
    logic            r5_nxneg, r5_nzneg;
    logic [15:0]     r5_u, r5_v;
    t_vflags         r5_flags;

    // stage 6: position products
    logic            r6_valid;
    logic [30:0]     r6_ppx, r6_ppy, r6_ppz;
    logic [14:0]     r6_nx, r6_ny, r6_nz;
    logic            r6_nxneg, r6_nzneg;
    logic [15:0]     r6_u, r6_v;
    t_vflags         r6_flags;

    // output beat
    logic                r_valid;
    logic signed [16:0]  r_pos_x, r_pos_y, r_pos_z;
    logic signed [15:0]  r_norm_x, r_norm_y, r_norm_z;
    logic [15:0]         r_tex_u, r_tex_v;
    logic                r_last, r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r1_valid <= i_req_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r_valid  <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_jj    <= i_req_jj;
        r1_ii    <= i_req_ii;
        r1_flags <= i_req_flags;
    end

    // split the longitude into quadrant and offset
    logic [15:0] w_jj16, w_m16, w_ii16;
    logic [2:0]  w_q;
    logic [15:0] w_m_ok, w_i_ok;

    always_comb begin
        w_jj16 = 16'(r1_jj);
        w_ii16 = 16'(r1_ii);
        priority if (w_jj16 >= r_q4) w_q = 3'd4;
        else if (w_jj16 >= r_q3)     w_q = 3'd3;
        else if (w_jj16 >= r_q2)     w_q = 3'd2;
        else if (w_jj16 >= r_q1)     w_q = 3'd1;
        else                         w_q = 3'd0;
        unique case (w_q)
            3'd0:    w_m16 = w_jj16;
            3'd1:    w_m16 = w_jj16 - r_q1;
            3'd2:    w_m16 = w_jj16 - r_q2;
            3'd3:    w_m16 = w_jj16 - r_q3;
            default: w_m16 = w_jj16 - r_q4;
        endcase
        // out of range only on a flagged cell, keep the address in the table
        w_m_ok = (w_m16 < r_q1) ? w_m16 : 16'd0;
        w_i_ok = (w_ii16 < r_q1) ? w_ii16 : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        r2_aj    <= r_base + AW'(w_m_ok);
        r2_ai    <= r_base + AW'(w_i_ok);
        r2_q     <= w_q;
        r2_flags <= r1_flags;
    end

    uvst_trig_rom #(
        .QMAX (QMAX),
        .AW   (AW)
    ) u_rom (
        .i_clk    (i_clk),
        .i_addr_a (r2_aj),
        .i_addr_b (r2_ai),
        .o_word_a (w_rom_j),
        .o_word_b (w_rom_i)
    );

    always_ff @(posedge i_clk) begin
        r3_q     <= r2_q;
        r3_flags <= r2_flags;
    end

    // quadrant mapping, sin/cos as sign and magnitude
    logic [30:0] w_sjm, w_cjm;
    logic        w_sjn, w_cjn;
    logic [31:0] w_ny_sum;

    always_comb begin
        unique case (r3_q[1:0])
            2'd0: begin
                w_sjm = w_rom_j.sv; w_sjn = 1'b0;
                w_cjm = w_rom_j.cv; w_cjn = 1'b0;
            end
            2'd1: begin
                w_sjm = w_rom_j.cv; w_sjn = 1'b0;
                w_cjm = w_rom_j.sv; w_cjn = 1'b1;
            end
            2'd2: begin
                w_sjm = w_rom_j.sv; w_sjn = 1'b1;
                w_cjm = w_rom_j.cv; w_cjn = 1'b1;
            end
            default: begin
                w_sjm = w_rom_j.cv; w_sjn = 1'b1;
                w_cjm = w_rom_j.sv; w_cjn = 1'b0;
            end
        endcase
        w_ny_sum = {1'b0, w_rom_i.sv} + 32'h0000_8000;
    end

    always_ff @(posedge i_clk) begin
        r4_pnx   <= {31'b0, w_sjm} * {31'b0, w_rom_i.cv};
        r4_pnz   <= {31'b0, w_cjm} * {31'b0, w_rom_i.cv};
        // x and z carry the negated sin/cos of the longitude
        r4_nxneg <= !w_sjn;
        r4_nzneg <= !w_cjn;
        r4_ny    <= 15'(w_ny_sum >> 16);
        r4_u     <= {r3_q, 13'b0} +
                    16'(r3_flags.apex ? w_rom_j.aoff : w_rom_j.uoff);
        r4_v     <= r3_flags.apex ? 16'd32768 : 16'd16384 + 16'(w_rom_i.voff);
        r4_flags <= r3_flags;
    end

    logic [61:0] w_rnx, w_rnz;
    assign w_rnx = (r4_pnx + (62'd1 << 45)) >> 46;
    assign w_rnz = (r4_pnz + (62'd1 << 45)) >> 46;

    always_ff @(posedge i_clk) begin
        if (r4_flags.apex) begin
            r5_nx <= 15'd0;
            r5_ny <= 15'd16384;
            r5_nz <= 15'd0;
        end else begin
            r5_nx <= 15'(w_rnx);
            r5_ny <= r4_ny;
            r5_nz <= 15'(w_rnz);
        end
        r5_nxneg <= r4_nxneg;
        r5_nzneg <= r4_nzneg;
        r5_u     <= r4_u;
        r5_v     <= r4_v;
        r5_flags <= r4_flags;
    end

    always_ff @(posedge i_clk) begin
        r6_ppx   <= 31'(i_radius) * 31'(r5_nx);
        r6_ppy   <= 31'(i_radius) * 31'(r5_ny);
        r6_ppz   <= 31'(i_radius) * 31'(r5_nz);
        r6_nx    <= r5_nx;
        r6_ny    <= r5_ny;
        r6_nz    <= r5_nz;
        r6_nxneg <= r5_nxneg;
        r6_nzneg <= r5_nzneg;
        r6_u     <= r5_u;
        r6_v     <= r5_v;
        r6_flags <= r5_flags;
    end

    logic [16:0] w_pxm, w_pym, w_pzm;
    assign w_pxm = 17'((r6_ppx + 31'd8192) >> 14);
    assign w_pym = 17'((r6_ppy + 31'd8192) >> 14);
    assign w_pzm = 17'((r6_ppz + 31'd8192) >> 14);

    always_ff @(posedge i_clk) begin
        if (r6_flags.bad) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
            r_norm_x <= '0;
            r_norm_y <= '0;
            r_norm_z <= '0;
            r_tex_u  <= '0;
            r_tex_v  <= '0;
        end else begin
            r_pos_x  <= r6_nxneg ? -w_pxm : w_pxm;
            r_pos_y  <= r6_flags.mir ? -w_pym : w_pym;
            r_pos_z  <= r6_nzneg ? -w_pzm : w_pzm;
            r_norm_x <= r6_nxneg ? -16'(r6_nx) : 16'(r6_nx);
            r_norm_y <= r6_flags.mir ? -16'(r6_ny) : 16'(r6_ny);
            r_norm_z <= r6_nzneg ? -16'(r6_nz) : 16'(r6_nz);
            r_tex_u  <= r6_u;
            r_tex_v  <= r6_flags.mir ? 16'd32768 - r6_v : r6_v;
        end
        r_last <= r6_flags.last;
        r_bad  <= r6_flags.bad;
    end

    assign o_valid       = r_valid;
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_norm_x      = r_norm_x;
    assign o_norm_y      = r_norm_y;
    assign o_norm_z      = r_norm_z;
    assign o_tex_u       = r_tex_u;
    assign o_tex_v       = r_tex_v;
    assign o_last_vertex = r_last;
    assign o_bad_cell    = r_bad;

endmodule

// ===== hw/rtl/uv_sphere_cell_tessellator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_cell_tessellator
// turns one (ring, segment) cell of a uv sphere into its triangle vertices
// ----------------------------------------------------------------------------
// A cell is taken when start is high and busy is low. It leaves as a burst of
// vertex beats on o_strobe, one beat per cycle, with o_last_vertex on the
// final one: 12 beats for an ordinary ring, 6 for the top ring (apex at the
// pole) and a single flagged beat with o_bad_cell for a cell outside the
// sphere. The result port has no stall, so whatever sits downstream must take
// every beat as it comes. The single vertex-per-cycle result port sets the
// rate: a new cell can be taken while the final request of the previous one
// is issued, so bursts run back to back, and busy only covers the expansion
// of the cell in flight. The user must write radius and resolution through
// the plain write port only while no cell is in flight; it is not enforced.
module uv_sphere_cell_tessellator #(
    parameter int unsigned MAX_RESOLUTION = 256,
    parameter int unsigned MIN_RESOLUTION = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // cell command
    input  logic                start,
    output logic                busy,
    input  logic [5:0]          i_ring,
    input  logic [7:0]          i_segment,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    // vertex beats
    output logic                o_strobe,
    output logic signed [16:0]  o_pos_x,
    output logic signed [16:0]  o_pos_y,
    output logic signed [16:0]  o_pos_z,
    output logic signed [15:0]  o_norm_x,
    output logic signed [15:0]  o_norm_y,
    output logic signed [15:0]  o_norm_z,
    output logic [15:0]         o_tex_u,
    output logic [15:0]         o_tex_v,
    output logic                o_last_vertex,
    output logic                o_bad_cell
);
    import uvst_pkg::*;

    // quarter circle counts and trig table geometry
    localparam int unsigned QMAX  = MAX_RESOLUTION / 4;
    localparam int unsigned QW    = $clog2(QMAX + 1);
    localparam int unsigned DEPTH = QMAX * (QMAX + 1) / 2;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CAP   = (MAX_RESOLUTION / 4) * 4;
    localparam int unsigned MINR4 = ((MIN_RESOLUTION + 3) / 4) * 4;

    logic [15:0] r_radius;
    logic [8:0]  r_resolution;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_RESET;
            r_resolution <= RESOLUTION_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS:     r_radius     <= i_cfg_data;
                REG_RESOLUTION: r_resolution <= i_cfg_data[8:0];
                default:        r_radius     <= r_radius;
            endcase
        end
    end

    // effective resolution: round up to four, raise to the floor, clamp
    logic [10:0]   w_round4, w_raised, w_eff;
    logic [QW-1:0] w_qn;

    always_comb begin
        w_round4 = (11'(r_resolution) + 11'd3) & ~11'd3;
        w_raised = (w_round4 < 11'(MINR4)) ? 11'(MINR4) : w_round4;
        w_eff    = (w_raised > 11'(CAP)) ? 11'(CAP) : w_raised;
    end

    assign w_qn = QW'(w_eff >> 2);

    // vertex requests from the expander
    logic            w_req_valid;
    logic [JW-1:0]   w_req_jj;
    logic [IW-1:0]   w_req_ii;
    t_vflags         w_req_flags;

    uvst_expander #(
        .QW (QW)
    ) u_expander (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_ring      (i_ring),
        .i_segment   (i_segment),
        .i_qn        (w_qn),
        .o_req_valid (w_req_valid),
        .o_req_jj    (w_req_jj),
        .o_req_ii    (w_req_ii),
        .o_req_flags (w_req_flags)
    );

    // seven register stages from request to vertex beat
    uvst_vertex_pipe #(
        .QMAX (QMAX),
        .QW   (QW),
        .AW   (AW)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qn          (w_qn),
        .i_radius      (r_radius),
        .i_req_valid   (w_req_valid),
        .i_req_jj      (w_req_jj),
        .i_req_ii      (w_req_ii),
        .i_req_flags   (w_req_flags),
        .o_valid       (o_strobe),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_pos_z       (o_pos_z),
        .o_norm_x      (o_norm_x),
        .o_norm_y      (o_norm_y),
        .o_norm_z      (o_norm_z),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_last_vertex (o_last_vertex),
        .o_bad_cell    (o_bad_cell)
    );

    // a taken command always starts a request burst
    a_accept_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> w_req_valid)
        else $error("accepted cell issued no vertex request");

    // busy only while a burst is being expanded
    a_busy_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (w_req_valid && !w_req_flags.last))
        else $error("busy without a burst in progress");

    // a flagged cell is a single all-zero beat
    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bad_cell) |-> (o_last_vertex && (o_pos_x == '0) &&
            (o_norm_y == '0) && (o_tex_u == '0) && (o_tex_v == '0)))
        else $error("bad cell beat carries data");

    // texture coordinates stay within one
    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_tex_u <= 16'd32768) && (o_tex_v <= 16'd32768)))
        else $error("texture coordinate above one");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the sphere cell tessellator against an own fixed-point vertex model
// ----------------------------------------------------------------------------
// Cells go in through the start/busy command port. Every taken cell is
// expanded into its vertex list by the model in the scoreboard. Each vertex
// beat on o_strobe is compared with the oldest vertex still owed. Trig-based
// fields get a one-LSB margin on the normal, scaled by the radius on the
// position. The run steps through several radius and resolution settings,
// the extremes among them, with random idle gaps on the command side.
// ----------------------------------------------------------------------------
module tb;
    import uvst_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 24;

    typedef struct {
        longint px, py, pz, nx, ny, nz;
        longint u, v;
        bit     last, bad;
    } t_vertex;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the registers and the owed vertex beats
    // ------------------------------------------------------------------------
    class vertex_scoreboard;
        int unsigned radius_q88;
        int unsigned res_req;
        t_vertex     owed_beats[$];
        int unsigned n_errors;
        int unsigned n_cells;
        int unsigned n_beats;

        function automatic longint unsigned rnd_div(longint unsigned num,
                                                    longint unsigned den);
            return (num + den / 2) / den;
        endfunction

        function automatic int unsigned eff_res();
            int unsigned r;
            r = res_req;
            if (r < 16) r = 16;
            if (r % 4 != 0) r += 4 - r % 4;
            if (r > 256) r = 256;
            return r;
        endfunction

        // sin and cos of k*2pi/r in q2.30
        function automatic void sin_cos_q30(int unsigned k, int unsigned r,
                                            output longint s, output longint c);
            longint unsigned one, x, x2, t;
            longint          sv, cv;
            int unsigned     qn, kk, quad, m;
            one  = 64'd1 << 30;
            qn   = r / 4;
            kk   = k % r;
            quad = kk / qn;
            m    = kk % qn;
            x    = rnd_div(longint'(m) * 64'd1686629713, qn);
            x2   = (x * x) >> 30;
            t = one - ((x2 * one / 156) >> 30);
            t = one - ((x2 * t / 110) >> 30);
            t = one - ((x2 * t / 72) >> 30);
            t = one - ((x2 * t / 42) >> 30);
            t = one - ((x2 * t / 20) >> 30);
            t = one - ((x2 * t / 6) >> 30);
            sv = longint'((x * t) >> 30);
            t = one - ((x2 * one / 132) >> 30);
            t = one - ((x2 * t / 90) >> 30);
            t = one - ((x2 * t / 56) >> 30);
            t = one - ((x2 * t / 30) >> 30);
            t = one - ((x2 * t / 12) >> 30);
            t = one - ((x2 * t / 2) >> 30);
            cv = longint'(t & 64'h7FFF_FFFF);
            case (quad & 3)
                0: begin s = sv;  c = cv;  end
                1: begin s = cv;  c = -sv; end
                2: begin s = -sv; c = -cv; end
                default: begin s = -cv; c = sv; end
            endcase
        endfunction

        function automatic longint unsigned magn(longint a);
            return (a < 0) ? longint'(-a) : a;
        endfunction

        function automatic longint q30_to_q14(longint a);
            longint r;
            r = longint'((magn(a) + (64'd1 << 15)) >> 16);
            return (a < 0) ? -r : r;
        endfunction

        function automatic longint mul_q14(longint a, longint b);
            longint r;
            r = longint'((magn(a) * magn(b) + (64'd1 << 45)) >> 46);
            return ((a < 0) != (b < 0)) ? -r : r;
        endfunction

        function automatic longint scale_by_radius(longint n);
            longint r;
            r = longint'((longint'(radius_q88) * magn(n) + 8192) >> 14);
            return (n < 0) ? -r : r;
        endfunction

        function automatic t_vertex corner(int unsigned j, int unsigned i,
                                           int unsigned r);
            t_vertex v;
            longint  sj, cj, si, ci;
            sin_cos_q30(j, r, sj, cj);
            sin_cos_q30(i, r, si, ci);
            v.nx = mul_q14(-sj, ci);
            v.ny = q30_to_q14(si);
            v.nz = mul_q14(-cj, ci);
            v.px = scale_by_radius(v.nx);
            v.py = scale_by_radius(v.ny);
            v.pz = scale_by_radius(v.nz);
            v.u  = rnd_div(longint'(j) * 32768, r);
            v.v  = 16384 + rnd_div(longint'(i) * 65536, r);
            v.last = 0;
            v.bad  = 0;
            return v;
        endfunction

        function automatic t_vertex flip_y(t_vertex v);
            v.ny = -v.ny;
            v.py = -v.py;
            v.v  = 32768 - v.v;
            return v;
        endfunction

        // expand one taken cell into the vertex beats it owes
        function automatic void note_cell(int unsigned ring, int unsigned seg);
            t_vertex     a, b, c, d, p, list[$];
            int unsigned r;
            r = eff_res();
            n_cells++;
            if (ring >= r / 4 || seg >= r) begin
                a = '{default: 0};
                a.last = 1;
                a.bad  = 1;
                list.push_back(a);
            end else if (ring + 1 < r / 4) begin
                a = corner(seg, ring, r);
                b = corner(seg + 1, ring, r);
                c = corner(seg + 1, ring + 1, r);
                d = corner(seg, ring + 1, r);
                list = '{a, b, c, c, d, a};
                a = flip_y(a); b = flip_y(b); c = flip_y(c); d = flip_y(d);
                list = {list, d, c, b, b, a, d};
            end else begin
                // top ring meets the pole apex
                a = corner(seg, ring, r);
                b = corner(seg + 1, ring, r);
                p = '{default: 0};
                p.ny = 16384;
                p.py = scale_by_radius(p.ny);
                p.u  = rnd_div(longint'(2 * seg + 1) * 16384, r);
                p.v  = 32768;
                list = '{a, b, p, flip_y(a), flip_y(p), flip_y(b)};
            end
            list[list.size() - 1].last = 1;
            owed_beats = {owed_beats, list};
        endfunction

        function automatic void cmp_field(string name, longint want, longint got,
                                          longint tol);
            longint diff;
            diff = want - got;
            if (diff > tol || diff < -tol) begin
                n_errors++;
                $display("%0t mismatch %s: expected %0d actual %0d", $time,
                         name, want, got);
            end
        endfunction

        function automatic void check_beat(t_vertex got);
            t_vertex want;
            longint  ptol;
            n_beats++;
            if (owed_beats.size() == 0) begin
                n_errors++;
                $display("%0t unexpected vertex beat: expected none actual pos %0d %0d %0d",
                         $time, got.px, got.py, got.pz);
                return;
            end
            want = owed_beats.pop_front();
            ptol = ((longint'(radius_q88) + 16383) >> 14) + 1;
            cmp_field("pos_x", want.px, got.px, ptol);
            cmp_field("pos_y", want.py, got.py, ptol);
            cmp_field("pos_z", want.pz, got.pz, ptol);
            cmp_field("norm_x", want.nx, got.nx, 1);
            cmp_field("norm_y", want.ny, got.ny, 1);
            cmp_field("norm_z", want.nz, got.nz, 1);
            cmp_field("tex_u", want.u, got.u, 0);
            cmp_field("tex_v", want.v, got.v, 0);
            cmp_field("last_vertex", want.last, got.last, 0);
            cmp_field("bad_cell", want.bad, got.bad, 0);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block and its ports
    // ------------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [5:0]         i_ring;
    logic [7:0]         i_segment;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               o_strobe;
    logic signed [16:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [15:0] o_norm_x, o_norm_y, o_norm_z;
    logic [15:0]        o_tex_u, o_tex_v;
    logic               o_last_vertex, o_bad_cell;

    uv_sphere_cell_tessellator i_dut (.*);

    vertex_scoreboard sb = new();
    int unsigned      idle_pct;      // chance of a gap after a command beat
    int unsigned      stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // command and vertex monitor, plus the no-progress watchdog
    always @(posedge i_clk) begin
        t_vertex got;
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            if (start && !busy) sb.note_cell(i_ring, i_segment);
            if (o_strobe) begin
                got.px = o_pos_x;  got.py = o_pos_y;  got.pz = o_pos_z;
                got.nx = o_norm_x; got.ny = o_norm_y; got.nz = o_norm_z;
                got.u  = o_tex_u;  got.v  = o_tex_v;
                got.last = o_last_vertex;
                got.bad  = o_bad_cell;
                sb.check_beat(got);
            end
            if ((start && !busy) || o_strobe) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // one command beat, then maybe a gap with start low
    task automatic send_cell(input int unsigned ring, input int unsigned seg);
        i_ring    <= ring[5:0];
        i_segment <= seg[7:0];
        start     <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    // settle: every owed beat in, then the DRAIN_CYCLES margin on top
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[15:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_RADIUS) sb.radius_q88 = value & 16'hFFFF;
        else                   sb.res_req    = value & 9'h1FF;
    endtask

    // mostly well-formed cells, biased to the top ring and the seam
    task automatic random_cells(input int unsigned count);
        int unsigned r, ring, seg, pick;
        r = sb.eff_res();
        repeat (count) begin
            pick = $urandom_range(99);
            ring = (pick < 12) ? r / 4 - 1 : $urandom_range(r / 4 - 1);
            seg  = (pick % 7 == 0) ? r - 1 : $urandom_range(r - 1);
            if (pick >= 88) ring = $urandom_range(63);
            if (pick >= 94) seg  = $urandom_range(255);
            send_cell(ring, seg);
        end
    endtask

    initial begin
        int unsigned setting_rad[6], setting_res[6];
        start      = 1'b0;
        i_ring     = '0;
        i_segment  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        idle_pct   = 22;
        sb.radius_q88 = RADIUS_RESET;
        sb.res_req    = RESOLUTION_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting, r = 16: every ring, top ring, seam, both bad sides
        send_cell(0, 0);
        send_cell(1, 5);
        send_cell(2, 15);
        send_cell(3, 0);
        send_cell(3, 15);
        send_cell(4, 0);
        send_cell(0, 16);
        send_cell(63, 255);
        send_cell(63, 0);
        send_cell(0, 255);
        send_cell(2, 8);
        drain();
        // zero radius and a tiny request; then largest radius, full resolution
        write_reg(REG_RADIUS, 0);
        write_reg(REG_RESOLUTION, 0);
        send_cell(0, 3);
        send_cell(3, 7);
        drain();
        write_reg(REG_RADIUS, 65535);
        write_reg(REG_RESOLUTION, 256);
        send_cell(0, 0);
        send_cell(63, 255);
        send_cell(62, 0);
        send_cell(63, 128);
        send_cell(42, 170);
        send_cell(21, 85);
        drain();

        setting_rad = '{256, 65535, 1, 12345, $urandom_range(65535), $urandom_range(65535)};
        setting_res = '{17, 511, 255, 30, $urandom_range(511), $urandom_range(16, 64)};
        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 22 : (ph < 4) ? 78 : 0;
            write_reg(REG_RADIUS, setting_rad[ph]);
            write_reg(REG_RESOLUTION, setting_res[ph]);
            random_cells(68);
            drain();
        end

        $display("covered %0d cells and %0d vertex beats over nine register settings",
                 sb.n_cells, sb.n_beats);
        $display("radius 0..65535, resolution requests 0..511, command gaps 22%%, 78%%, none");
        if (sb.n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
